// ===== rtl/mrta_pkg.sv =====
// mrta_pkg: shared types and constants of the threshold alarm unit
// used by mrta_front, mrta_back, the top level and the checker; no dependencies
package mrta_pkg;

  // default number of rule slots and its ceiling
  localparam int DEFAULT_RULE_SLOTS = 8;
  localparam int MAX_RULE_SLOTS     = 8;

  // field widths
  localparam int FIELD_W     = 4;
  localparam int VALUE_W     = 32;
  localparam int RULE_W      = 64;
  localparam int THR_W       = 28;
  localparam int HYS_W       = 28;
  localparam int IDX_W       = 3;
  localparam int CFG_INDEX_W = 4;
  // compare width: value, threshold +/- hysteresis all fit without wrap
  localparam int CMP_W       = 34;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // comparison codes of a rule word
  typedef enum logic [2:0] {
    OP_GT = 3'd0,
    OP_GE = 3'd1,
    OP_LT = 3'd2,
    OP_LE = 3'd3,
    OP_EQ = 3'd4
  } op_t;

  // command of an input word
  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_RESET = 1'b1
  } cmd_t;

  // kind of an output event
  typedef enum logic {
    EV_FIRED   = 1'b0,
    EV_CLEARED = 1'b1
  } kind_t;

  // rule word layout, msb first
  typedef struct packed {
    logic [HYS_W-1:0]   hys;
    logic [THR_W-1:0]   thr;
    logic               enable;
    logic [2:0]         op;
    logic [FIELD_W-1:0] field;
  } rule_t;

  // one classified input word
  typedef struct packed {
    cmd_t                       cmd;
    logic [FIELD_W-1:0]         field;
    logic signed [VALUE_W-1:0]  value;
  } item_t;

  // queue head as seen by the back part
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

endpackage

// ===== rtl/mrta_front.sv =====
// mrta_front: input acceptance, command decode and a two-entry word queue
// depends on mrta_pkg
module mrta_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               reading_valid,
  output logic                               reading_stall,
  input  logic                               cmd,
  input  logic [mrta_pkg::FIELD_W-1:0]        field_id,
  input  logic signed [mrta_pkg::VALUE_W-1:0] reading_value,
  input  logic                               pop,
  output mrta_pkg::queue_t                   head
);

  mrta_pkg::item_t                mem [mrta_pkg::QUEUE_DEPTH];
  logic [mrta_pkg::QPTR_W-1:0]    wr_ptr;
  logic [mrta_pkg::QPTR_W-1:0]    rd_ptr;
  logic [mrta_pkg::QCNT_W-1:0]    count;
  logic                           push;
  logic                           pop_fire;
  mrta_pkg::item_t                item_in;

  // classify the incoming word
  always_comb begin
    item_in.cmd   = cmd ? mrta_pkg::CMD_RESET : mrta_pkg::CMD_READ;
    item_in.field = field_id;
    item_in.value = reading_value;
  end

  assign reading_stall = (count == mrta_pkg::QCNT_W'(mrta_pkg::QUEUE_DEPTH));
  assign push          = reading_valid && !reading_stall;
  assign pop_fire      = pop && (count != '0);

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)     wr_ptr <= wr_ptr + 1'b1;
      if (pop_fire) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop_fire})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= item_in;
  end

  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

endmodule

// ===== rtl/mrta_back.sv =====
// mrta_back: rule registers, armed flags, slot-serial scan and event output register
// depends on mrta_pkg; fed by mrta_front through its queue head
module mrta_back #(
  parameter int RULE_SLOTS = mrta_pkg::DEFAULT_RULE_SLOTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mrta_pkg::queue_t                    head,
  output logic                                pop,
  input  logic                                cfg_valid,
  input  logic [mrta_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mrta_pkg::RULE_W-1:0]          cfg_data,
  output logic                                event_valid,
  input  logic                                event_stall,
  output logic [mrta_pkg::IDX_W-1:0]           rule_index,
  output logic                                event_kind,
  output logic [mrta_pkg::FIELD_W-1:0]         reported_field,
  output logic signed [mrta_pkg::VALUE_W-1:0]  observed_value,
  output logic                                last_flag
);

  localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CMP_W  = mrta_pkg::CMP_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                               state;
  mrta_pkg::rule_t                      rules [RULE_SLOTS];
  logic [RULE_SLOTS-1:0]                armed;
  logic [SLOT_W-1:0]                    slot;
  logic [mrta_pkg::FIELD_W-1:0]         cur_field;
  logic signed [mrta_pkg::VALUE_W-1:0]  cur_value;
  logic [RULE_SLOTS-1:0]                ev_mask;
  logic [RULE_SLOTS-1:0]                ev_kind;

  mrta_pkg::rule_t                      rule;
  logic signed [CMP_W-1:0]              v_x;
  logic signed [CMP_W-1:0]              thr_x;
  logic signed [CMP_W-1:0]              hys_x;
  logic signed [CMP_W-1:0]              lo_x;
  logic signed [CMP_W-1:0]              hi_x;
  logic                                 trip;
  logic                                 untrip;
  logic                                 hit;
  logic                                 fire;
  logic                                 clr;
  logic                                 scan_end;
  logic [SLOT_W-1:0]                    sel;
  logic [RULE_SLOTS-1:0]                sel_oh;
  logic [RULE_SLOTS-1:0]                rest;
  logic                                 out_free;
  logic                                 load;

  assign pop = (state == ST_IDLE);

  // evaluate the current slot against the held reading
  always_comb begin
    rule  = rules[slot];
    v_x   = CMP_W'(cur_value);
    thr_x = CMP_W'($signed(rule.thr));
    hys_x = $signed({{(CMP_W-mrta_pkg::HYS_W){1'b0}}, rule.hys});
    lo_x  = thr_x - hys_x;
    hi_x  = thr_x + hys_x;
    case (mrta_pkg::op_t'(rule.op))
      mrta_pkg::OP_GT: begin trip = v_x >  thr_x; untrip = v_x <= lo_x;  end
      mrta_pkg::OP_GE: begin trip = v_x >= thr_x; untrip = v_x <  lo_x;  end
      mrta_pkg::OP_LT: begin trip = v_x <  thr_x; untrip = v_x >= hi_x;  end
      mrta_pkg::OP_LE: begin trip = v_x <= thr_x; untrip = v_x >  hi_x;  end
      mrta_pkg::OP_EQ: begin trip = v_x == thr_x; untrip = v_x != thr_x; end
      default:         begin trip = 1'b0;         untrip = 1'b0;         end
    endcase
    hit  = rule.enable && (rule.field == cur_field);
    fire = hit && !armed[slot] && trip;
    clr  = hit && armed[slot] && untrip;
  end

  assign scan_end = (slot == SLOT_W'(RULE_SLOTS - 1));

  // lowest pending event
  always_comb begin
    sel    = '0;
    sel_oh = '0;
    for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
      if (ev_mask[i]) begin
        sel    = SLOT_W'(i);
        sel_oh = '0;
        sel_oh[i] = 1'b1;
      end
    end
    rest = ev_mask & ~sel_oh;
  end

  assign out_free = !event_valid || !event_stall;
  assign load     = (state == ST_EMIT) && out_free;

  // sequencer, rule registers and armed flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      armed       <= '0;
      event_valid <= 1'b0;
      for (int i = 0; i < RULE_SLOTS; i++) rules[i] <= '0;
    end else begin
      if (cfg_valid && (cfg_index < mrta_pkg::CFG_INDEX_W'(RULE_SLOTS))) begin
        rules[cfg_index[SLOT_W-1:0]] <= mrta_pkg::rule_t'(cfg_data);
      end
      if (load) begin
        event_valid <= 1'b1;
      end else if (out_free) begin
        event_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            if (head.item.cmd == mrta_pkg::CMD_RESET) begin
              armed <= '0;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (fire || clr) armed[slot] <= fire;
          if (scan_end) begin
            state <= ((ev_mask != '0) || fire || clr) ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free && (rest == '0)) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // held reading, slot counter, event mask and output word
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      cur_field <= head.item.field;
      cur_value <= head.item.value;
      slot      <= '0;
      ev_mask   <= '0;
    end else if (state == ST_SCAN) begin
      if (fire || clr) begin
        ev_mask[slot] <= 1'b1;
        ev_kind[slot] <= clr;
      end
      slot <= slot + 1'b1;
    end else if (load) begin
      ev_mask <= rest;
    end
    if (load) begin
      rule_index     <= mrta_pkg::IDX_W'(sel);
      event_kind     <= ev_kind[sel] ? mrta_pkg::EV_CLEARED : mrta_pkg::EV_FIRED;
      reported_field <= cur_field;
      observed_value <= cur_value;
      last_flag      <= (rest == '0);
    end
  end

endmodule

// ===== rtl/multi_rule_threshold_alarm_unit.sv =====
// multi_rule_threshold_alarm_unit: top level of the threshold alarm with hysteresis
// depends on mrta_pkg, mrta_front and mrta_back
//
//   channel   handshake                  word
//   reading   reading_valid/_stall       cmd, field_id, reading_value
//   event     event_valid/_stall         rule_index, event_kind, reported_field,
//                                        observed_value, last_flag
//   config    cfg_valid/cfg_ready        cfg_index, cfg_data
//
// a reading word is scanned in the back part one slot per cycle through the single
// compare unit, then its events load one per cycle into the output register unless stalled
// a reset word clears the armed flags as it is popped; a two-word queue sits between front and back
// rst is synchronous: clears rule registers, armed flags, queue and output valid
// event_stall holds the output register; the front keeps accepting until the queue fills
// cfg_ready is always high
module multi_rule_threshold_alarm_unit #(
  parameter int RULE_SLOTS = mrta_pkg::DEFAULT_RULE_SLOTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                reading_valid,
  output logic                                reading_stall,
  input  logic                                cmd,
  input  logic [mrta_pkg::FIELD_W-1:0]         field_id,
  input  logic signed [mrta_pkg::VALUE_W-1:0]  reading_value,
  output logic                                event_valid,
  input  logic                                event_stall,
  output logic [mrta_pkg::IDX_W-1:0]           rule_index,
  output logic                                event_kind,
  output logic [mrta_pkg::FIELD_W-1:0]         reported_field,
  output logic signed [mrta_pkg::VALUE_W-1:0]  observed_value,
  output logic                                last_flag,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mrta_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mrta_pkg::RULE_W-1:0]          cfg_data
);

  mrta_pkg::queue_t head;
  logic             pop;

  assign cfg_ready = 1'b1;

  // accept and queue input words
  mrta_front u_front (
    .clk           (clk),
    .rst           (rst),
    .reading_valid (reading_valid),
    .reading_stall (reading_stall),
    .cmd           (cmd),
    .field_id      (field_id),
    .reading_value (reading_value),
    .pop           (pop),
    .head          (head)
  );

  // scan rules and emit events
  mrta_back #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .event_valid    (event_valid),
    .event_stall    (event_stall),
    .rule_index     (rule_index),
    .event_kind     (event_kind),
    .reported_field (reported_field),
    .observed_value (observed_value),
    .last_flag      (last_flag)
  );

endmodule

// ===== rtl/mrta_checker.sv =====
// mrta_checker: port-level assertions for the threshold alarm unit, bound to the top level
// depends on mrta_pkg and multi_rule_threshold_alarm_unit
module mrta_checker #(
  parameter int RULE_SLOTS = mrta_pkg::DEFAULT_RULE_SLOTS
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                event_valid,
  input logic                                event_stall,
  input logic [mrta_pkg::IDX_W-1:0]           rule_index,
  input logic                                event_kind,
  input logic [mrta_pkg::FIELD_W-1:0]         reported_field,
  input logic signed [mrta_pkg::VALUE_W-1:0]  observed_value,
  input logic                                last_flag
);

  // a stalled event word holds: index, kind, value and last flag stay stable
  a_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_stall |=> event_valid && $stable(rule_index)
      && $stable(event_kind) && $stable(observed_value) && $stable(last_flag))
    else $error("stalled event word changed");

  // nothing is shown right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !event_valid)
    else $error("event valid after reset");

  // only existing slots report
  a_slot: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> rule_index <= mrta_pkg::IDX_W'(RULE_SLOTS - 1))
    else $error("event from a slot beyond the rule count");

  // events of one reading follow back to back in rising slot order
  a_burst: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_stall && !last_flag |=> event_valid
      && (rule_index > $past(rule_index))
      && (reported_field == $past(reported_field))
      && (observed_value == $past(observed_value)))
    else $error("event burst broken or out of order");

endmodule

bind multi_rule_threshold_alarm_unit mrta_checker #(
  .RULE_SLOTS (RULE_SLOTS)
) u_mrta_checker (
  .clk            (clk),
  .rst            (rst),
  .event_valid    (event_valid),
  .event_stall    (event_stall),
  .rule_index     (rule_index),
  .event_kind     (event_kind),
  .reported_field (reported_field),
  .observed_value (observed_value),
  .last_flag      (last_flag)
);
